// ===== rtl/core/assert_macros.svh =====
// assertion macros for the rtl, included by datagram_session_receiver_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define DSR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dsr assertion failed");

// clocked check that also holds during reset
`define DSR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dsr assertion failed");

`endif

// ===== rtl/core/dsr_pkg.sv =====
// types, codes and constants of the datagram session receiver
package dsr_pkg;

  // result codes
  typedef enum logic [2:0] {
    ACT_DELIVER = 3'd0,
    ACT_CONNACC = 3'd1,
    ACT_CONRJT  = 3'd2,
    ACT_ACC     = 3'd3,
    ACT_RJT     = 3'd4,
    ACT_RCVD    = 3'd5,
    ACT_ABORT   = 3'd6
  } action_e;

  // session phase, one-hot
  typedef enum logic [1:0] {
    PH_IDLE = 2'b01,
    PH_OPEN = 2'b10
  } phase_e;

  // event kind carried on tuser
  localparam logic CMD_HEADER  = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  localparam logic [7:0] TYPE_CONN   = 8'd1;
  localparam logic [7:0] TYPE_DATA   = 8'd4;
  localparam logic [7:0] PROTO_PLAIN = 8'd2;
  localparam logic [7:0] PROTO_ACKED = 8'd3;

  localparam logic [7:0] MAX_RETRIES_RST = 8'd5;

  // results one event can cause, and result queue depth
  localparam int RES_MAX = 3;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic        cmd;
    logic [7:0]  pkt_type;
    logic [63:0] pkt_session;
    logic [63:0] pkt_number;
    logic [63:0] pkt_length;
    logic [7:0]  proto_id;
    logic        conn_size_ok;
  } event_t;

  typedef struct packed {
    phase_e      phase;
    logic        reliable;
    logic [63:0] session;
    logic [63:0] expected;
    logic [63:0] remaining;
    logic [7:0]  retries;
  } sess_state_t;

  typedef struct packed {
    action_e     action;
    logic [63:0] session;
    logic [63:0] number;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0]                count;
    result_t [RES_MAX-1:0]     item;
  } result_batch_t;

endpackage

// ===== rtl/core/dsr_step.sv =====
// per-event decision logic: next session state and the results of one event
module dsr_step import dsr_pkg::*; (
  input  event_t        evt_i,
  input  sess_state_t   state_i,
  input  logic [7:0]    max_retries_i,
  output sess_state_t   state_o,
  output result_batch_t batch_o
);

  logic        conn_ok;
  logic        sess_match;
  logic        data_match;
  logic        retry_ok;
  logic [63:0] rem_left;

  // header classification
  assign conn_ok = (evt_i.cmd == CMD_HEADER) && evt_i.conn_size_ok &&
                   (evt_i.pkt_type == TYPE_CONN) &&
                   ((evt_i.proto_id == PROTO_PLAIN) || (evt_i.proto_id == PROTO_ACKED));
  assign sess_match = (evt_i.pkt_type == TYPE_DATA) &&
                      (evt_i.pkt_session == state_i.session);
  assign data_match = sess_match && (evt_i.pkt_number == state_i.expected);
  assign retry_ok   = state_i.retries < max_retries_i;

  // remaining byte count saturates at zero
  assign rem_left = (evt_i.pkt_length >= state_i.remaining) ? 64'd0 :
                    state_i.remaining - evt_i.pkt_length;

  always_comb begin
    sess_state_t   nxt;
    result_batch_t b;
    logic [1:0]    n;
    nxt = state_i;
    b   = '0;
    n   = 2'd0;
    case (state_i.phase)
      PH_IDLE: begin
        // open a session on a fitting connect header
        if (conn_ok) begin
          nxt.session   = evt_i.pkt_session;
          nxt.reliable  = (evt_i.proto_id == PROTO_ACKED);
          nxt.remaining = evt_i.pkt_length;
          nxt.expected  = 64'd0;
          nxt.retries   = 8'd0;
          nxt.phase     = PH_OPEN;
          b.item[n] = '{action: ACT_CONNACC, session: evt_i.pkt_session,
                        number: 64'd0, last: 1'b0};
          n = n + 2'd1;
          if (evt_i.pkt_length == 64'd0) begin
            b.item[n] = '{action: ACT_RCVD, session: evt_i.pkt_session,
                          number: 64'd0, last: 1'b0};
            n = n + 2'd1;
            nxt.phase = PH_IDLE;
          end
        end
      end
      PH_OPEN: begin
        if (evt_i.cmd == CMD_TIMEOUT) begin
          // timeout: re-acknowledge or abort
          if (state_i.reliable && retry_ok) begin
            nxt.retries = state_i.retries + 8'd1;
            if (state_i.expected != 64'd0) begin
              b.item[n] = '{action: ACT_ACC, session: state_i.session,
                            number: state_i.expected - 64'd1, last: 1'b0};
              n = n + 2'd1;
            end
          end else begin
            b.item[n] = '{action: ACT_ABORT, session: state_i.session,
                          number: 64'd0, last: 1'b0};
            n = n + 2'd1;
            nxt.phase = PH_IDLE;
          end
        end else if (data_match) begin
          // in-order data packet
          nxt.retries = 8'd0;
          b.item[n] = '{action: ACT_DELIVER, session: state_i.session,
                        number: evt_i.pkt_number, last: 1'b0};
          n = n + 2'd1;
          if (state_i.reliable) begin
            b.item[n] = '{action: ACT_ACC, session: state_i.session,
                          number: evt_i.pkt_number, last: 1'b0};
            n = n + 2'd1;
          end
          nxt.remaining = rem_left;
          nxt.expected  = state_i.expected + 64'd1;
          if (rem_left == 64'd0) begin
            b.item[n] = '{action: ACT_RCVD, session: state_i.session,
                          number: 64'd0, last: 1'b0};
            n = n + 2'd1;
            nxt.phase = PH_IDLE;
          end
        end else if (evt_i.pkt_type == TYPE_CONN) begin
          // second connect while busy
          nxt.retries = 8'd0;
          b.item[n] = '{action: ACT_CONRJT, session: evt_i.pkt_session,
                        number: 64'd0, last: 1'b0};
          n = n + 2'd1;
        end else if (sess_match) begin
          // out-of-order data packet of this session
          if (state_i.reliable) begin
            if (retry_ok) begin
              nxt.retries = state_i.retries + 8'd1;
              if (state_i.expected != 64'd0) begin
                b.item[n] = '{action: ACT_ACC, session: state_i.session,
                              number: state_i.expected - 64'd1, last: 1'b0};
                n = n + 2'd1;
              end
            end else begin
              b.item[n] = '{action: ACT_ABORT, session: state_i.session,
                            number: 64'd0, last: 1'b0};
              n = n + 2'd1;
              nxt.phase = PH_IDLE;
            end
          end else begin
            b.item[n] = '{action: ACT_RJT, session: state_i.session,
                          number: state_i.expected, last: 1'b0};
            n = n + 2'd1;
            nxt.phase = PH_IDLE;
          end
        end else begin
          // foreign traffic
          if (state_i.reliable) begin
            nxt.retries = 8'd0;
          end
        end
      end
      default: begin
        nxt.phase = PH_IDLE;
      end
    endcase
    // mark the final result of this event
    for (int i = 0; i < RES_MAX; i++) begin
      b.item[i].last = (n == 2'(i + 1));
    end
    b.count = n;
    state_o = nxt;
    batch_o = b;
  end

endmodule

// ===== rtl/core/datagram_session_receiver_core.sv =====
// top level of the datagram session receiver
// One event (a received header or a receive timeout) is taken per cycle and decided in
// the same cycle; its zero to three results enter a four-entry result queue. With the
// master side ready, results leave one per cycle and, as the slave side is ready while
// at most one result is queued, events that cause one result or none flow at one per
// cycle; the output's one result per cycle sets the rate for events with two or three.
// Session state updates as each event is taken; back-to-back events see it at once.
module datagram_session_receiver_core import dsr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write: max_retries
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_data_i,
  // events in
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [7:0] pkt_type, [71:8] pkt_session, [135:72] pkt_number, [199:136] pkt_length,
  // [207:200] proto_id, [208] conn_size_ok, [215:209] zero
  input  logic [215:0] s_axis_tdata_i,
  // [0] cmd
  input  logic         s_axis_tuser_i,
  // results out
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [2:0] action, [66:3] out_session, [130:67] out_number, [135:131] zero
  output logic [135:0] m_axis_tdata_o,
  output logic         m_axis_tlast_o
);

  `include "assert_macros.svh"

  logic [7:0]        max_retries_q;
  sess_state_t       state_q, state_d;
  event_t            evt;
  result_batch_t     batch;
  result_t           res_mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              s_accept, m_accept;
  result_t           head;
  action_e           last_act;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_retries_q <= MAX_RETRIES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_retries_q <= cfg_data_i;
    end
  end

  // unpack the incoming transaction
  assign evt.cmd          = s_axis_tuser_i;
  assign evt.pkt_type     = s_axis_tdata_i[7:0];
  assign evt.pkt_session  = s_axis_tdata_i[71:8];
  assign evt.pkt_number   = s_axis_tdata_i[135:72];
  assign evt.pkt_length   = s_axis_tdata_i[199:136];
  assign evt.proto_id     = s_axis_tdata_i[207:200];
  assign evt.conn_size_ok = s_axis_tdata_i[208];

  assign s_axis_tready_o = (count_q <= QCNT_W'(1));
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  dsr_step u_step (
    .evt_i         (evt),
    .state_i       (state_q),
    .max_retries_i (max_retries_q),
    .state_o       (state_d),
    .batch_o       (batch)
  );

  // session state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, reliable: 1'b0, session: 64'd0, expected: 64'd0,
                   remaining: 64'd0, retries: 8'd0};
    end else if (s_accept) begin
      state_q <= state_d;
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < RES_MAX; k++) begin
      if (s_accept && (2'(k) < batch.count)) begin
        res_mem_q[wr_ptr_q + QPTR_W'(k)] <= batch.item[k];
      end
    end
  end

  // result queue pointers and fill count
  assign m_accept = m_axis_tvalid_o && m_axis_tready_i;
  assign count_d  = count_q + (s_accept ? QCNT_W'(batch.count) : QCNT_W'(0))
                    - QCNT_W'(m_accept);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (s_accept) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(batch.count);
      end
      if (m_accept) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  // result output
  assign head            = res_mem_q[rd_ptr_q];
  assign m_axis_tvalid_o = (count_q != '0);
  assign m_axis_tdata_o  = {5'd0, head.number, head.session, head.action};
  assign m_axis_tlast_o  = head.last;

  // action of the final result of the event being taken
  assign last_act = batch.item[batch.count - 2'd1].action;

  `DSR_ASSERT_ALWAYS(a_count_bound, clk_i, (!rst_ni) || (count_q <= QCNT_W'(QDEPTH)))
  `DSR_ASSERT(a_ptr_consistent, clk_i, rst_ni,
    (rd_ptr_q + count_q[QPTR_W-1:0]) == wr_ptr_q)
  `DSR_ASSERT(a_close_reason, clk_i, rst_ni,
    (s_accept && state_q.phase == PH_OPEN && state_d.phase == PH_IDLE) |->
      (last_act == ACT_RCVD || last_act == ACT_ABORT || last_act == ACT_RJT))

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the datagram session receiver core
module tb;
  import dsr_pkg::*;

  localparam int SETTLE      = 16;
  localparam int LIMIT       = 400000;
  localparam int PHASE_ITEMS = 29;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES      = 8;

  // session tracker and store of replies still owed by the block
  class session_scoreboard;
    logic [7:0]  max_retries;
    bit          open;
    bit          acked;
    logic [63:0] session;
    logic [63:0] expected;
    logic [63:0] remaining;
    logic [7:0]  retries;
    result_t     replies_due[$];
    int          errors;

    function new();
      max_retries = MAX_RETRIES_RST;
      open        = 1'b0;
      acked       = 1'b0;
      session     = '0;
      expected    = '0;
      remaining   = '0;
      retries     = '0;
      errors      = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("tb: mismatch %0d: %s", errors, msg);
    endtask

    function void owe(action_e act, logic [63:0] sess, logic [63:0] num);
      result_t r;
      r.action  = act;
      r.session = sess;
      r.number  = num;
      r.last    = 1'b0;
      replies_due.push_back(r);
    endfunction

    // re-acknowledge the previous packet, or abort once the retries are spent
    function void reack();
      if (retries < max_retries) begin
        retries = retries + 8'd1;
        if (expected != 0) owe(ACT_ACC, session, expected - 64'd1);
      end else begin
        owe(ACT_ABORT, session, '0);
        open = 1'b0;
      end
    endfunction

    // work out the replies to one accepted event
    function void absorb_event(event_t ev);
      int      n0;
      result_t r;
      n0 = replies_due.size();
      if (!open) begin
        if (ev.cmd == CMD_HEADER && ev.conn_size_ok && ev.pkt_type == TYPE_CONN &&
            (ev.proto_id == PROTO_PLAIN || ev.proto_id == PROTO_ACKED)) begin
          session   = ev.pkt_session;
          acked     = (ev.proto_id == PROTO_ACKED);
          remaining = ev.pkt_length;
          expected  = '0;
          retries   = '0;
          open      = 1'b1;
          owe(ACT_CONNACC, ev.pkt_session, '0);
          if (remaining == 0) begin
            owe(ACT_RCVD, ev.pkt_session, '0);
            open = 1'b0;
          end
        end
      end else if (ev.cmd == CMD_TIMEOUT) begin
        if (acked) begin
          reack();
        end else begin
          owe(ACT_ABORT, session, '0);
          open = 1'b0;
        end
      end else if (ev.pkt_type == TYPE_DATA && ev.pkt_session == session &&
                   ev.pkt_number == expected) begin
        retries = '0;
        owe(ACT_DELIVER, session, ev.pkt_number);
        if (acked) owe(ACT_ACC, session, ev.pkt_number);
        remaining = (ev.pkt_length >= remaining) ? 64'd0 : remaining - ev.pkt_length;
        expected  = expected + 64'd1;
        if (remaining == 0) begin
          owe(ACT_RCVD, session, '0);
          open = 1'b0;
        end
      end else if (ev.pkt_type == TYPE_CONN) begin
        retries = '0;
        owe(ACT_CONRJT, ev.pkt_session, '0);
      end else if (ev.pkt_type == TYPE_DATA && ev.pkt_session == session) begin
        if (acked) begin
          reack();
        end else begin
          owe(ACT_RJT, session, expected);
          open = 1'b0;
        end
      end else if (acked) begin
        retries = '0;
      end
      // flag the final reply of this event
      if (replies_due.size() > n0) begin
        r = replies_due[replies_due.size() - 1];
        r.last = 1'b1;
        replies_due[replies_due.size() - 1] = r;
      end
    endfunction

    // compare one reply with the oldest one owed
    task check_reply(result_t got);
      result_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("unexpected reply, action %0d", got.action));
        return;
      end
      want = replies_due.pop_front();
      if (got.action !== want.action)
        report($sformatf("action got %0d want %0d", got.action, want.action));
      if (got.session !== want.session)
        report($sformatf("session got %h want %h", got.session, want.session));
      if (got.number !== want.number)
        report($sformatf("number got %h want %h", got.number, want.number));
      if (got.last !== want.last)
        report($sformatf("last got %b want %b", got.last, want.last));
    endtask
  endclass

  logic         clk_i     = 1'b0;
  logic         rst_ni    = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_data  = '0;
  logic         s_valid   = 1'b0;
  logic         s_ready;
  logic [215:0] s_data    = '0;
  logic         s_user    = 1'b0;
  logic         m_valid;
  logic         m_ready   = 1'b0;
  logic [135:0] m_data;
  logic         m_last;

  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_token = 0;
  int rx_seen    = 0;
  int rx_hold    = 0;
  int cycles     = 0;

  session_scoreboard sb = new();

  datagram_session_receiver_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last)
  );

  // clock
  always #2 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_token != rx_seen) begin
      rx_seen <= hold_token;
      rx_hold <= HOLD_CYCLES;
      m_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // reply monitor
  always @(posedge clk_i) begin : reply_mon
    result_t got;
    if (rst_ni && m_valid && m_ready) begin
      got.action  = action_e'(m_data[2:0]);
      got.session = m_data[66:3];
      got.number  = m_data[130:67];
      got.last    = m_last;
      sb.check_reply(got);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic event_t header(logic [7:0] kind, logic [63:0] sess, logic [63:0] num,
                                    logic [63:0] len, logic [7:0] proto, logic ok);
    event_t ev;
    ev.cmd          = CMD_HEADER;
    ev.pkt_type     = kind;
    ev.pkt_session  = sess;
    ev.pkt_number   = num;
    ev.pkt_length   = len;
    ev.proto_id     = proto;
    ev.conn_size_ok = ok;
    return ev;
  endfunction

  // timeout with junk in the header fields
  function automatic event_t timeout_event();
    event_t ev;
    ev = header(8'($urandom), rand64(), rand64(), rand64(), 8'($urandom), 1'($urandom));
    ev.cmd = CMD_TIMEOUT;
    return ev;
  endfunction

  // mostly well-formed sessions, with errors and noise mixed in
  function automatic event_t random_event();
    event_t ev;
    int     r;
    ev = header(8'($urandom), rand64(), rand64(), rand64(), 8'($urandom), 1'($urandom));
    r  = $urandom_range(0, 99);
    if (!sb.open) begin
      if (r < 75) begin
        ev.pkt_type     = TYPE_CONN;
        ev.conn_size_ok = 1'b1;
        ev.proto_id     = $urandom_range(0, 1) ? PROTO_ACKED : PROTO_PLAIN;
        ev.pkt_session  = $urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 3));
        ev.pkt_length   = ($urandom_range(0, 9) == 0) ? 64'd0 : 64'($urandom_range(1, 40));
      end else if (r < 85) begin
        ev = timeout_event();
      end else if (r < 92) begin
        ev.pkt_type = TYPE_CONN;
      end
    end else begin
      if (r < 60) begin
        ev.pkt_type    = TYPE_DATA;
        ev.pkt_session = sb.session;
        ev.pkt_number  = sb.expected;
        ev.pkt_length  = ($urandom_range(0, 19) == 0) ? rand64() : 64'($urandom_range(0, 15));
      end else if (r < 68) begin
        ev = timeout_event();
      end else if (r < 76) begin
        ev.pkt_type    = TYPE_DATA;
        ev.pkt_session = sb.session;
        ev.pkt_number  = $urandom_range(0, 1) ? sb.expected - 64'd1 : rand64();
      end else if (r < 82) begin
        ev.pkt_type    = TYPE_DATA;
        ev.pkt_session = sb.session ^ (64'd1 << $urandom_range(0, 63));
        ev.pkt_number  = sb.expected;
      end else if (r < 88) begin
        ev.pkt_session = sb.session;
        ev.pkt_number  = sb.expected;
      end else if (r < 93) begin
        ev.pkt_type = TYPE_CONN;
      end
    end
    return ev;
  endfunction

  // offer one event and wait for its transaction; valid stays high afterwards
  task automatic send_event(event_t ev);
    s_valid <= 1'b1;
    s_user  <= ev.cmd;
    s_data  <= {7'b0, ev.conn_size_ok, ev.proto_id, ev.pkt_length, ev.pkt_number,
                ev.pkt_session, ev.pkt_type};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    sb.absorb_event(ev);
  endtask

  // stop offering and wait until every owed reply has come
  task automatic drain();
    s_valid <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_max_retries(logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    sb.max_retries = value;
  endtask

  initial begin : stim
    event_t     dir[$];
    logic [7:0] retry_set[PHASES];
    logic [63:0] s1;
    logic [63:0] s2;
    logic [63:0] s3;
    s1 = 64'h0123_4567_89ab_cdef;
    s2 = 64'h8000_0000_0000_0001;
    s3 = 64'hfedc_ba98_7654_3210;
    retry_set = '{8'd0, 8'd255, 8'd1, 8'($urandom), 8'd2, 8'd255, 8'd0, 8'($urandom)};

    // idle: timeout, bad size, wrong type, bad protocol
    dir.push_back(timeout_event());
    dir.push_back(header(TYPE_CONN, s1, '0, 64'd100, PROTO_PLAIN, 1'b0));
    dir.push_back(header(TYPE_DATA, s1, '0, 64'd100, PROTO_PLAIN, 1'b1));
    dir.push_back(header(TYPE_CONN, s1, '0, 64'd100, 8'hff, 1'b1));
    // zero length connect opens and closes at once
    dir.push_back(header(TYPE_CONN, '1, '1, '0, PROTO_PLAIN, 1'b1));
    // plain session: deliver, connect rejected, foreign and other type ignored, bad number
    dir.push_back(header(TYPE_CONN, s1, '0, 64'd100, PROTO_PLAIN, 1'b1));
    dir.push_back(header(TYPE_DATA, s1, '0, 64'd10, '0, 1'b0));
    dir.push_back(header(TYPE_CONN, s2, '0, 64'd5, PROTO_ACKED, 1'b1));
    dir.push_back(header(TYPE_DATA, ~s1, 64'd1, 64'd10, '0, 1'b0));
    dir.push_back(header(8'hff, s1, 64'd1, 64'd10, '0, 1'b0));
    dir.push_back(header(TYPE_DATA, s1, '1, 64'd10, '0, 1'b0));
    // plain session ended by a timeout
    dir.push_back(header(TYPE_CONN, s1, '0, '1, PROTO_PLAIN, 1'b1));
    dir.push_back(timeout_event());
    // acknowledged: retry before any packet, duplicate, foreign clears, oversize length
    dir.push_back(header(TYPE_CONN, s2, '0, 64'd20, PROTO_ACKED, 1'b1));
    dir.push_back(timeout_event());
    dir.push_back(header(TYPE_DATA, s2, '0, 64'd5, '0, 1'b0));
    dir.push_back(header(TYPE_DATA, s2, '0, 64'd5, '0, 1'b0));
    dir.push_back(header(TYPE_DATA, s1, 64'd1, 64'd5, '0, 1'b0));
    dir.push_back(header(TYPE_DATA, s2, 64'd1, '1, '0, 1'b0));
    // acknowledged: retries run out and the session aborts
    dir.push_back(header(TYPE_CONN, s3, '0, 64'd50, PROTO_ACKED, 1'b1));
    repeat (6) dir.push_back(timeout_event());

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir[i]) send_event(dir[i]);
    drain();

    // random phases over retry limits and idling patterns
    for (int p = 0; p < PHASES; p++) begin
      write_max_retries(retry_set[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 87; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 87; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      // long receiver hold-off so the result queue fills and the input stalls
      if (p == 0) hold_token <= hold_token + 1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < idle_pct) begin
          s_valid <= 1'b0;
          do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
        end
        if (p == 1 && i == PHASE_ITEMS / 2) drain();
        send_event(random_event());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
